>>> rtl/core/iee_pkg.sv
package iee_pkg;

  localparam int StackDepthDef   = 64;
  localparam int ValueWidthDef   = 32;
  localparam int FractionBitsDef = 16;
  localparam int OutWidth        = 32;

  typedef enum logic [2:0] {
    TokNum   = 3'd0,
    TokAdd   = 3'd1,
    TokSub   = 3'd2,
    TokMul   = 3'd3,
    TokDiv   = 3'd4,
    TokOpen  = 3'd5,
    TokClose = 3'd6,
    TokEnd   = 3'd7
  } tok_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StOverflow = 3'd1,
    StMissing  = 3'd2,
    StUnmatch  = 3'd3,
    StDivZero  = 3'd4
  } status_e;

  function automatic logic op_rank(input logic [2:0] op);
    return (op == TokMul) || (op == TokDiv);
  endfunction

endpackage

>>> rtl/core/iee_ram.sv
module iee_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/iee_alu.sv
// Shared arithmetic unit: add/sub registered straight from idle, multiply over
// half-width partial products, divide one quotient bit per cycle.
module iee_alu import iee_pkg::*; #(
  parameter int ValueWidth   = ValueWidthDef,
  parameter int FractionBits = FractionBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [2:0]            op_i,
  input  logic [ValueWidth-1:0] a_i,
  input  logic [ValueWidth-1:0] b_i,
  output logic                  done_o,
  output logic [ValueWidth-1:0] res_o,
  output logic                  div_zero_o
);

  localparam int W     = ValueWidth;
  localparam int PW    = 2 * W;
  localparam int DW    = W + FractionBits;
  localparam int HalfW = (W + 1) / 2;
  localparam int CntW  = $clog2(DW + 1);

  typedef enum logic [2:0] {
    AIdle, AMulLL, AMulLH, AMulHL, AMulHH, AMulFin, ADiv, ADone
  } alu_e;

  alu_e              state_q;
  logic              neg_q;
  logic [W-1:0]      ma_q, mb_q;
  logic [PW-1:0]     acc_q;
  logic [DW-1:0]     dvd_q;
  logic [W:0]        rem_q;
  logic [CntW-1:0]   cnt_q;
  logic [W-1:0]      res_q;
  logic              dz_q;

  logic [W-1:0]      ma_w, mb_w;
  logic              na_w, nb_w;
  logic [HalfW-1:0]  al, ah, bl, bh;
  logic [2*HalfW-1:0] pp;
  logic [W:0]        rsh, rsub;
  logic [W:0]        sum_w;

  assign na_w = a_i[W-1];
  assign nb_w = b_i[W-1];
  assign ma_w = na_w ? (~a_i + 1'b1) : a_i;
  assign mb_w = nb_w ? (~b_i + 1'b1) : b_i;

  assign al = HalfW'(ma_q);
  assign ah = HalfW'(ma_q >> HalfW);
  assign bl = HalfW'(mb_q);
  assign bh = HalfW'(mb_q >> HalfW);

  always_comb begin
    unique case (state_q)
      AMulLL:  pp = al * bl;
      AMulLH:  pp = al * bh;
      AMulHL:  pp = ah * bl;
      default: pp = ah * bh;
    endcase
  end

  assign rsh  = {rem_q[W-1:0], dvd_q[DW-1]};
  assign rsub = rsh - {1'b0, mb_q};

  // saturate a sign and wide magnitude to the signed range
  function automatic logic [W-1:0] sat(input logic neg, input logic ovf,
                                       input logic [W:0] m);
    logic [W:0] lim;
    logic [W:0] v;
    lim = neg ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
    v = (ovf || (m > lim)) ? lim : m;
    return neg ? W'(~v + 1'b1) : W'(v);
  endfunction

  always_comb begin
    logic sa, sb;
    sa = na_w;
    sb = nb_w ^ (op_i == TokSub);
    if (sa == sb) sum_w = {1'b0, ma_w} + {1'b0, mb_w};
    else if (ma_w >= mb_w) sum_w = {1'b0, ma_w - mb_w};
    else sum_w = {1'b0, mb_w - ma_w};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AIdle;
      dz_q    <= 1'b0;
    end else begin
      unique case (state_q)
        AIdle: if (start_i) begin
          ma_q  <= ma_w;
          mb_q  <= mb_w;
          acc_q <= '0;
          dz_q  <= 1'b0;
          neg_q <= na_w ^ nb_w;
          if (op_i == TokAdd || op_i == TokSub) begin
            if (na_w == (nb_w ^ (op_i == TokSub))) begin
              res_q <= sat(na_w, 1'b0, sum_w);
            end else if (ma_w >= mb_w) begin
              res_q <= sat(na_w, 1'b0, sum_w);
            end else begin
              res_q <= sat(nb_w ^ (op_i == TokSub), 1'b0, sum_w);
            end
            state_q <= ADone;
          end else if (op_i == TokMul) begin
            state_q <= AMulLL;
          end else if (mb_w == '0) begin
            dz_q    <= 1'b1;
            res_q   <= sat(na_w, 1'b1, '0);
            state_q <= ADone;
          end else begin
            dvd_q   <= {ma_w, {FractionBits{1'b0}}};
            rem_q   <= '0;
            cnt_q   <= CntW'(DW);
            state_q <= ADiv;
          end
        end
        AMulLL: begin
          acc_q   <= acc_q + PW'(pp);
          state_q <= AMulLH;
        end
        AMulLH: begin
          acc_q   <= acc_q + (PW'(pp) << HalfW);
          state_q <= AMulHL;
        end
        AMulHL: begin
          acc_q   <= acc_q + (PW'(pp) << HalfW);
          state_q <= AMulHH;
        end
        AMulHH: begin
          acc_q   <= acc_q + (PW'(pp) << (2 * HalfW));
          state_q <= AMulFin;
        end
        AMulFin: begin
          acc_q   <= acc_q >> FractionBits;
          state_q <= ADiv;
          cnt_q   <= '0;
        end
        ADiv: begin
          if (cnt_q == '0) begin
            // acc_q holds the quotient or the shifted product
            res_q   <= sat(neg_q, |acc_q[PW-1:W+1], acc_q[W:0]);
            state_q <= ADone;
          end else begin
            cnt_q <= cnt_q - 1'b1;
            dvd_q <= dvd_q << 1;
            if (!rsub[W]) begin
              rem_q <= rsub;
              acc_q <= {acc_q[PW-2:0], 1'b1};
            end else begin
              rem_q <= rsh;
              acc_q <= {acc_q[PW-2:0], 1'b0};
            end
          end
        end
        ADone: state_q <= AIdle;
        default: state_q <= AIdle;
      endcase
    end
  end

  assign done_o     = (state_q == ADone);
  assign res_o      = res_q;
  assign div_zero_o = dz_q;

  property p_done_pulse;
    @(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o;
  endproperty
  assert property (p_done_pulse) else $error("alu done held");

  property p_start_idle;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == AIdle && start_i) |=> (state_q != AIdle);
  endproperty
  assert property (p_start_idle) else $error("alu start lost");

  property p_res_hold;
    @(posedge clk_i) disable iff (!rst_ni) done_o |=> $stable(res_q);
  endproperty
  assert property (p_res_hold) else $error("alu result moved");

endmodule

>>> rtl/core/infix_expression_evaluator_top.sv
// channel | signals                              | dir
// in      | in_valid_i/in_ready_o token_kind_i number_value_i | in
// out     | out_valid_o/out_ready_i result_value_o status_o   | out
// Numbers and opens go Idle, Dispatch, Push. Each reduction reads both operands
// from the stack, then runs the shared unit; divide is a 48-bit
// restoring loop there. End reduces what is left, then goes EndTop, EndOut, Out.
// Stack reads go through registered RAMs; one read/write port each.
// Reset clears counts and error; stack contents stay undefined.
// A pending result blocks new requests until taken.
module infix_expression_evaluator_top import iee_pkg::*; #(
  parameter int STACK_DEPTH   = StackDepthDef,
  parameter int VALUE_WIDTH   = ValueWidthDef,
  parameter int FRACTION_BITS = FractionBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          token_kind_i,
  input  logic signed [31:0]  number_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  result_value_o,
  output logic [2:0]          status_o
);

  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    SIdle, SDispatch, SOpWait, SOpChk, SRdB, SRdA, SAluGo, SAluWait,
    SCloseDone, SEndTop, SEndOut, SPush, SOut
  } st_e;

  st_e            state_q;
  logic [2:0]     tok_q;
  logic [W-1:0]   num_q;
  logic [CW-1:0]  ncnt_q, ocnt_q;
  logic [2:0]     err_q;
  logic [2:0]     rop_q;
  logic [W-1:0]   b_q;
  logic [31:0]    res_q;
  logic [2:0]     stat_q;

  logic           nwe, owe;
  logic [AW-1:0]  nwa, nra, owa, ora;
  logic [W-1:0]   nwd, nrd;
  logic [2:0]     owd, ord_w;
  logic           alu_start, alu_done, alu_dz;
  logic [W-1:0]   alu_res;

  iee_ram #(.Width(W), .Depth(STACK_DEPTH)) u_nram (
    .clk_i, .we_i(nwe), .waddr_i(nwa), .wdata_i(nwd),
    .raddr_i(nra), .rdata_o(nrd));

  iee_ram #(.Width(3), .Depth(STACK_DEPTH)) u_oram (
    .clk_i, .we_i(owe), .waddr_i(owa), .wdata_i(owd),
    .raddr_i(ora), .rdata_o(ord_w));

  iee_alu #(.ValueWidth(W), .FractionBits(FRACTION_BITS)) u_alu (
    .clk_i, .rst_ni, .start_i(alu_start), .op_i(rop_q),
    .a_i(nrd), .b_i(b_q), .done_o(alu_done), .res_o(alu_res),
    .div_zero_o(alu_dz));

  function automatic logic [2:0] first_err(input logic [2:0] e, input logic [2:0] c);
    return (e == StOk) ? c : e;
  endfunction

  // input saturated into VALUE_WIDTH
  logic [W-1:0] num_sat;
  always_comb begin
    if (W >= 32) begin
      num_sat = W'($signed(number_value_i));
    end else if ($signed(number_value_i) > $signed(33'(({1'b0, {(W-1){1'b1}}}))))
    begin
      num_sat = {1'b0, {(W-1){1'b1}}};
    end else if ($signed(number_value_i) < -$signed(33'({1'b1, {(W-1){1'b0}}})))
    begin
      num_sat = {1'b1, {(W-1){1'b0}}};
    end else begin
      num_sat = W'(number_value_i);
    end
  end

  // output saturated to 32 bits
  logic [31:0] out_sat;
  always_comb begin
    logic [W+31:0] sx;
    sx = (W+32)'($signed(nrd));
    if (W <= 32) out_sat = 32'($signed(nrd));
    else if ($signed(sx) > $signed((W+32)'(32'h7fffffff))) out_sat = 32'h7fffffff;
    else if ($signed(sx) < -$signed((W+32)'(33'h080000000))) out_sat = 32'h80000000;
    else out_sat = sx[31:0];
  end

  logic top_stops;
  always_comb begin
    if (ord_w == TokOpen) top_stops = 1'b1;
    else if (tok_q == TokClose || tok_q == TokEnd) top_stops = 1'b0;
    else top_stops = op_rank(ord_w) < op_rank(tok_q);
  end

  // top in OpChk lands in RdB, second in RdB/RdA lands in RdA/AluGo
  assign nra = (state_q == SRdB || state_q == SRdA) ? AW'(ncnt_q - 2'd2) :
               AW'(ncnt_q - 1'b1);
  assign ora = AW'(ocnt_q - 1'b1);

  always_comb begin
    nwe = 1'b0; nwa = AW'(ncnt_q); nwd = num_q;
    owe = 1'b0; owa = AW'(ocnt_q); owd = tok_q;
    alu_start = (state_q == SAluGo);
    if (state_q == SPush && tok_q == TokNum && ncnt_q < CW'(STACK_DEPTH)) nwe = 1'b1;
    if (state_q == SPush && tok_q != TokNum && ocnt_q < CW'(STACK_DEPTH)) owe = 1'b1;
    if (state_q == SAluWait && alu_done) begin
      nwe = 1'b1; nwa = AW'(ncnt_q - 2'd2); nwd = alu_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ncnt_q  <= '0;
      ocnt_q  <= '0;
      err_q   <= StOk;
    end else begin
      unique case (state_q)
        SIdle: if (in_valid_i) begin
          tok_q   <= token_kind_i;
          num_q   <= num_sat;
          state_q <= SDispatch;
        end
        SDispatch: begin
          if (tok_q == TokNum || tok_q == TokOpen) state_q <= SPush;
          else state_q <= SOpWait;
        end
        SOpWait: state_q <= SOpChk;   // op RAM read data lands
        SOpChk: begin
          if (ocnt_q == '0) begin
            if (tok_q == TokClose) begin
              err_q <= first_err(err_q, StUnmatch);
              state_q <= SIdle;
            end else if (tok_q == TokEnd) begin
              state_q <= SEndTop;
            end else begin
              state_q <= SPush;
            end
          end else if (ord_w == TokOpen && tok_q == TokClose) begin
            ocnt_q <= ocnt_q - 1'b1;
            state_q <= SIdle;
          end else if (ord_w == TokOpen && tok_q == TokEnd) begin
            ocnt_q <= ocnt_q - 1'b1;
            err_q <= first_err(err_q, StUnmatch);
            state_q <= SOpWait;
          end else if (top_stops) begin
            state_q <= SPush;
          end else begin
            rop_q  <= ord_w;
            ocnt_q <= ocnt_q - 1'b1;
            if (ncnt_q < CW'(2)) begin
              err_q <= first_err(err_q, StMissing);
              state_q <= SOpWait;
            end else begin
              state_q <= SRdB;
            end
          end
        end
        SRdB: begin
          b_q     <= nrd;               // top of number stack
          state_q <= SRdA;
        end
        SRdA: state_q <= SAluGo;        // second operand read in flight
        SAluGo: state_q <= SAluWait;
        SAluWait: if (alu_done) begin
          if (alu_dz) err_q <= first_err(err_q, StDivZero);
          ncnt_q  <= ncnt_q - 1'b1;
          state_q <= SCloseDone;
        end
        SCloseDone: state_q <= SOpWait;  // let RAM write settle
        SEndTop: state_q <= SEndOut;
        SEndOut: begin
          if (ncnt_q == '0) begin
            res_q  <= '0;
            stat_q <= first_err(err_q, StMissing);
          end else begin
            res_q  <= out_sat;
            stat_q <= (ncnt_q > CW'(1)) ? first_err(err_q, StMissing) : err_q;
          end
          ncnt_q  <= '0;
          ocnt_q  <= '0;
          err_q   <= StOk;
          state_q <= SOut;
        end
        SPush: begin
          if (tok_q == TokNum) begin
            if (ncnt_q < CW'(STACK_DEPTH)) ncnt_q <= ncnt_q + 1'b1;
            else err_q <= first_err(err_q, StOverflow);
          end else begin
            if (ocnt_q < CW'(STACK_DEPTH)) ocnt_q <= ocnt_q + 1'b1;
            else err_q <= first_err(err_q, StOverflow);
          end
          state_q <= SIdle;
        end
        SOut: if (out_ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  assign in_ready_o     = (state_q == SIdle);
  assign out_valid_o    = (state_q == SOut);
  assign result_value_o = res_q;
  assign status_o       = stat_q;

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(result_value_o));
  endproperty
  assert property (p_out_hold) else $error("result dropped");

  property p_not_busy;
    @(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o;
  endproperty
  assert property (p_not_busy) else $error("ready during result");

  property p_cnt_range;
    @(posedge clk_i) disable iff (!rst_ni)
      (ncnt_q <= CW'(STACK_DEPTH)) && (ocnt_q <= CW'(STACK_DEPTH));
  endproperty
  assert property (p_cnt_range) else $error("stack count out of range");

  property p_clear_after_end;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == SEndOut) |=> (ncnt_q == '0 && ocnt_q == '0 && err_q == StOk);
  endproperty
  assert property (p_clear_after_end) else $error("stacks not cleared");

endmodule

>>> tb/sv/iee_checker.sv
module iee_checker import iee_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         token_kind_i,
  input  logic signed [31:0] number_value_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] result_value_i,
  input  logic [2:0]         status_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int Depth = StackDepthDef;
  localparam logic signed [63:0] VMax = 64'sd2147483647;
  localparam logic signed [63:0] VMin = -64'sd2147483648;

  logic signed [63:0] num_stk [Depth];
  logic [2:0]         op_stk [Depth];
  int                 num_cnt;
  int                 op_cnt;
  logic [2:0]         err;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } eval_result_t;

  eval_result_t results_q[$];

  function automatic logic signed [63:0] clamp(input logic signed [127:0] v);
    if (v > VMax) return VMax;
    if (v < VMin) return VMin;
    return v[63:0];
  endfunction

  task automatic note_err(input status_e code);
    if (err == StOk) err = code;
  endtask

  // Division truncates toward zero on magnitudes; a zero divisor saturates.
  task automatic apply_top_op();
    logic [2:0] op;
    logic signed [127:0] a, b, q;
    logic [127:0] ma, mb;
    op_cnt--;
    op = op_stk[op_cnt];
    if (num_cnt < 2) begin
      note_err(StMissing);
      return;
    end
    b = num_stk[num_cnt-1];
    a = num_stk[num_cnt-2];
    case (op)
      TokAdd: q = a + b;
      TokSub: q = a - b;
      TokMul: begin
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        q = (ma * mb) >> FractionBitsDef;
        if ((a < 0) != (b < 0)) q = -q;
      end
      default: begin
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        if (mb == 0) begin
          note_err(StDivZero);
          q = (a < 0) ? VMin : VMax;
        end else begin
          q = (ma << FractionBitsDef) / mb;
          if ((a < 0) != (b < 0)) q = -q;
        end
      end
    endcase
    num_cnt--;
    num_stk[num_cnt-1] = clamp(q);
  endtask

  task automatic push_op(input logic [2:0] op);
    if (op_cnt >= Depth) note_err(StOverflow);
    else begin
      op_stk[op_cnt] = op;
      op_cnt++;
    end
  endtask

  function automatic int prio(input logic [2:0] op);
    return (op == TokMul || op == TokDiv) ? 2 : 1;
  endfunction

  task automatic eval_token(input logic [2:0] kind, input logic signed [31:0] val);
    eval_result_t r;
    case (kind) inside
      TokNum: begin
        if (num_cnt >= Depth) note_err(StOverflow);
        else begin
          num_stk[num_cnt] = val;
          num_cnt++;
        end
      end
      TokAdd, TokSub, TokMul, TokDiv: begin
        while (op_cnt > 0 && op_stk[op_cnt-1] != TokOpen
               && prio(op_stk[op_cnt-1]) >= prio(kind))
          apply_top_op();
        push_op(kind);
      end
      TokOpen: push_op(TokOpen);
      TokClose: begin
        while (op_cnt > 0 && op_stk[op_cnt-1] != TokOpen) apply_top_op();
        if (op_cnt == 0) note_err(StUnmatch);
        else op_cnt--;
      end
      default: begin
        while (op_cnt > 0) begin
          if (op_stk[op_cnt-1] == TokOpen) begin
            op_cnt--;
            note_err(StUnmatch);
          end else apply_top_op();
        end
        if (num_cnt == 0) begin
          note_err(StMissing);
          r.value = '0;
        end else begin
          if (num_cnt > 1) note_err(StMissing);
          r.value = num_stk[num_cnt-1][31:0];
        end
        r.status = err;
        results_q.push_back(r);
        num_cnt = 0;
        op_cnt = 0;
        err = StOk;
      end
    endcase
  endtask

  assign pending_o = results_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    eval_result_t e;
    if (!rst_ni) begin
      num_cnt = 0;
      op_cnt = 0;
      err = StOk;
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) eval_token(token_kind_i, number_value_i);
      if (out_valid_i && out_ready_i) begin
        if (results_q.size() == 0) begin
          $display("%0t: unexpected result value=%0d status=%0d",
                   $time, result_value_i, status_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = results_q.pop_front();
          if (e.value !== result_value_i || e.status !== status_i) begin
            $display("%0t: mismatch expected value=%0d status=%0d, got value=%0d status=%0d",
                     $time, e.value, e.status, result_value_i, status_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/infix_expression_evaluator_top_tb.sv
module infix_expression_evaluator_top_tb import iee_pkg::*;;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         token_kind;
  logic signed [31:0] number_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] result_value;
  logic [2:0]         status;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  longint             cycle_cnt;

  infix_expression_evaluator_top DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .token_kind_i(token_kind), .number_value_i(number_value),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .result_value_o(result_value), .status_o(status)
  );

  iee_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .token_kind_i(token_kind), .number_value_i(number_value),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .result_value_i(result_value), .status_i(status),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // valid stays up across back-to-back requests; dropped only while idling
  task automatic send(input tok_e kind, input logic signed [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    token_kind <= kind;
    number_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_num();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $urandom;
      default: return $signed($urandom_range(32'h3ffff)) - 32'sh20000;
    endcase
  endfunction

  // Well-formed expression with random content; depth bounds nesting.
  task automatic send_operand(input int depth);
    if (depth > 0 && $urandom_range(3) == 0) begin
      send(TokOpen, $urandom);
      send_expr(depth - 1);
      send(TokClose, $urandom);
    end else
      send(TokNum, rand_num());
  endtask

  task automatic send_expr(input int depth);
    int n;
    n = $urandom_range(3);
    send_operand(depth);
    repeat (n) begin
      send(tok_e'($urandom_range(TokAdd, TokDiv)), $urandom);
      send_operand(depth);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int exprs);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (exprs) begin
      if ($urandom_range(9) < 8) send_expr(2);
      else repeat ($urandom_range(1, 6)) send(tok_e'($urandom_range(TokNum, TokClose)), $urandom);
      send(TokEnd, $urandom);
    end
  endtask

  initial begin
    in_valid = 1'b0;
    token_kind = TokNum;
    number_value = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cycle_cnt = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, every operator, special cases
    send(TokNum, 32'sh7fffffff); send(TokAdd, 0); send(TokNum, 32'sh00010000);
    send(TokEnd, 0);
    send(TokNum, 32'sh80000000); send(TokSub, 0); send(TokNum, 32'sh00010000);
    send(TokMul, 0); send(TokNum, 32'sh00020000); send(TokEnd, 0);
    send(TokNum, 32'sh00050000); send(TokDiv, 0); send(TokNum, 0); send(TokEnd, 0);
    send(TokNum, 32'sh80000000); send(TokDiv, 0); send(TokNum, 0); send(TokEnd, 0);
    send(TokEnd, 0);
    send(TokClose, 0); send(TokNum, 32'sh00030000); send(TokEnd, 0);
    send(TokOpen, 0); send(TokNum, -32'sh00018000); send(TokEnd, 0);
    send(TokNum, 1); send(TokNum, 2); send(TokAdd, 0); send(TokEnd, 0);
    send(TokNum, 32'sh00010000); send(TokMul, 0); send(TokOpen, 0);
    send(TokNum, 32'sh00020000); send(TokSub, 0); send(TokNum, 32'sh00030000);
    send(TokClose, 0); send(TokEnd, 0);
    // fill past the stack depth
    repeat (StackDepthDef + 2) send(TokNum, $urandom);
    repeat (StackDepthDef + 2) send(TokOpen, 0);
    send(TokEnd, 0);

    run_phase(0, 0, 7);
    run_phase(69, 0, 6);
    run_phase(0, 69, 6);
    run_phase(32, 32, 6);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
